/* rtl/rgb_to_hsl_unit_assert.svh */
// Assertion macros for the RGB to HSL converter.
// Used by rgb_to_hsl_unit only; no other dependencies.
`ifndef RGB_TO_HSL_UNIT_ASSERT_SVH
`define RGB_TO_HSL_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define RHU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_to_hsl_unit check failed");
// Next-cycle implication outside reset.
`define RHU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_to_hsl_unit check failed");
`endif

/* rtl/rhu_pkg.sv */
// Shared types and constants of the RGB to HSL converter.
// No dependencies.
`timescale 1ns / 1ps
package rhu_pkg;
  localparam int CompBits  = 16;
  localparam int HueBits   = 15;
  // Quotient bits kept from each divider (the low bits of its quotient).
  localparam int QBits     = 16;
  // Divider operand width: numerator is 65535*x or 3840*x, x < 2^17.
  localparam int NumBits   = 33;
  localparam int DenBits   = 17;
  localparam int Stages    = NumBits;
  localparam logic [15:0] HueSector = 16'd3840;
  localparam logic [14:0] HueFull   = 15'd23040;
  localparam logic [0:0]  RegMaxComp = 1'b0;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } in_word_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] saturation;
    logic [15:0] lightness;
    logic        achromatic;
  } out_word_t;

  // Side data that travels with each divider chain.
  typedef struct packed {
    logic        achro;
    logic        neg;     // hue numerator negative
    logic [14:0] base;    // sector offset
  } side_t;
endpackage

/* rtl/rhu_div_cell.sv */
// One restoring-division step: produces one quotient bit per cycle while en is high.
// Depends on rhu_pkg.
`timescale 1ns / 1ps
module rhu_div_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rhu_pkg::NumBits-1:0]   num_i,
  input  logic [rhu_pkg::DenBits-1:0]   den_i,
  input  logic [rhu_pkg::DenBits:0]     rem_i,
  input  logic [rhu_pkg::NumBits-1:0]   quo_i,
  output logic [rhu_pkg::NumBits-1:0]   num_o,
  output logic [rhu_pkg::DenBits-1:0]   den_o,
  output logic [rhu_pkg::DenBits:0]     rem_o,
  output logic [rhu_pkg::NumBits-1:0]   quo_o
);
  import rhu_pkg::*;
  logic [DenBits+1:0] trial;
  logic [DenBits:0]   rem_nxt;
  logic               bit_nxt;

  // Shift in the next numerator bit and try a subtract.
  always_comb begin
    trial = {rem_i, num_i[NumBits-1]} - {2'b00, den_i};
    bit_nxt = !trial[DenBits+1];
    rem_nxt = bit_nxt ? trial[DenBits:0] : {rem_i[DenBits-1:0], num_i[NumBits-1]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_o <= {num_i[NumBits-2:0], 1'b0};
      den_o <= den_i;
      rem_o <= rem_nxt;
      quo_o <= {quo_i[NumBits-2:0], bit_nxt};
    end
  end
endmodule

/* rtl/rhu_div_chain.sv */
// Pipelined unsigned divider: a row of rhu_div_cell stages.
// Depends on rhu_pkg and rhu_div_cell.
`timescale 1ns / 1ps
module rhu_div_chain (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rhu_pkg::NumBits-1:0] num_i,
  input  logic [rhu_pkg::DenBits-1:0] den_i,
  input  logic [rhu_pkg::NumBits-1:0] rem_flag_i,
  output logic [rhu_pkg::QBits-1:0]   quo_o,
  output logic                        rem_nz_o,
  output logic [rhu_pkg::NumBits-1:0] rem_flag_o
);
  import rhu_pkg::*;
  logic [NumBits-1:0] num_s [Stages+1];
  logic [DenBits-1:0] den_s [Stages+1];
  logic [DenBits:0]   rem_s [Stages+1];
  logic [NumBits-1:0] quo_s [Stages+1];

  assign num_s[0] = num_i;
  assign den_s[0] = den_i;
  assign rem_s[0] = '0;
  // quo lane carries the side flags in, shifted out as quotient shifts in
  assign quo_s[0] = rem_flag_i;

  for (genvar k = 0; k < Stages; k++) begin : g_cell
    rhu_div_cell u_cell (
      .clk(clk), .en(en),
      .num_i(num_s[k]), .den_i(den_s[k]), .rem_i(rem_s[k]), .quo_i(quo_s[k]),
      .num_o(num_s[k+1]), .den_o(den_s[k+1]), .rem_o(rem_s[k+1]),
      .quo_o(quo_s[k+1])
    );
  end

  assign quo_o      = quo_s[Stages][QBits-1:0];
  assign rem_nz_o   = |rem_s[Stages];
  assign rem_flag_o = {num_s[Stages][NumBits-1:1], |den_s[Stages]};
endmodule

/* rtl/rgb_to_hsl_unit.sv */
// RGB to HSL converter: one pixel per clock while not stalled, fully pipelined:
// two prep stages, three 33-cell restoring divider chains (one quotient bit
// per cell) and an output register. A waiting result freezes the whole pipe,
// so in_stall follows out_stall while the output register is full.
// Depends on rhu_pkg, rhu_div_chain and the assert header.
`timescale 1ns / 1ps
module rgb_to_hsl_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rhu_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rhu_pkg::out_word_t  out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import rhu_pkg::*;
  `include "rgb_to_hsl_unit_assert.svh"
  localparam int Lat = Stages + 2;

  logic [15:0] max_comp_r;
  logic        en;
  logic [Lat-1:0] vld_r;
  out_word_t   out_r;
  logic        out_vld_r;

  // Config register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == RegMaxComp) ? {16'd0, max_comp_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_comp_r <= 16'd255;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == RegMaxComp) begin
      max_comp_r <= cfg_pwdata[15:0];
    end
  end

  // Pipeline advances unless the output register is full and stalled.
  assign en       = !(out_vld_r && out_stall);
  assign in_stall = !en;

  // Stage 0: clamp, min/max, hue difference and sector base
  logic [15:0] m, r, g, b, mx, mn;
  always_comb begin
    m  = (max_comp_r == 16'd0) ? 16'd1 : max_comp_r;
    r  = (in_data.red   > m) ? m : in_data.red;
    g  = (in_data.green > m) ? m : in_data.green;
    b  = (in_data.blue  > m) ? m : in_data.blue;
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
  end

  logic [15:0] m_r, mx_r, mn_r;
  logic [16:0] diff_r;  // signed hue difference, sign in [16]
  logic [14:0] base_r;
  always_ff @(posedge clk) begin
    if (en) begin
      m_r  <= m;
      mx_r <= mx;
      mn_r <= mn;
      if (r == mx) begin
        diff_r <= {1'b0, g} - {1'b0, b};
        base_r <= 15'd0;
      end else if (g == mx) begin
        diff_r <= {1'b0, b} - {1'b0, r};
        base_r <= 15'd7680;
      end else begin
        diff_r <= {1'b0, r} - {1'b0, g};
        base_r <= 15'd15360;
      end
    end
  end

  // Stage 1: operands for the three dividers
  logic [16:0] s1, d1, two_m, den_sat, adiff;
  logic        neg1;
  logic [NumBits-1:0] n_l, n_s, n_h;
  always_comb begin
    s1    = {1'b0, mx_r} + {1'b0, mn_r};
    d1    = {1'b0, mx_r} - {1'b0, mn_r};
    two_m = {m_r, 1'b0};
    den_sat = (s1 < {1'b0, m_r}) ? s1 : (two_m - s1);
    neg1  = diff_r[16];
    adiff = neg1 ? (17'd0 - diff_r) : diff_r;
    n_l = 33'({s1, 16'd0} - {16'd0, s1});
    n_s = 33'({d1, 16'd0} - {16'd0, d1});
    n_h = 33'(adiff) * 33'(HueSector);
  end

  logic [NumBits-1:0] nl_r, ns_r, nh_r;
  logic [DenBits-1:0] dl_r, ds_r, dh_r;
  side_t              side_r;
  always_ff @(posedge clk) begin
    if (en) begin
      nl_r <= n_l;  dl_r <= two_m;
      ns_r <= n_s;  ds_r <= (d1 == 17'd0) ? 17'd1 : den_sat;
      nh_r <= n_h;  dh_r <= (d1 == 17'd0) ? 17'd1 : d1;
      side_r <= '{achro: (d1 == 17'd0), neg: neg1, base: base_r};
    end
  end

  // Divider chains; side data rides in a separate delay line, flag lanes tied to zero.
  logic [QBits-1:0]   ql, qs, qh;
  logic               rl_nz, rs_nz, rh_nz;
  logic [NumBits-1:0] fl, fs, fh;
  logic [NumBits-1:0] side_in;
  side_t              side_q;
  assign side_in = '0;
  rhu_div_chain u_light (.clk(clk), .en(en), .num_i(nl_r), .den_i(dl_r),
    .rem_flag_i(side_in), .quo_o(ql), .rem_nz_o(rl_nz), .rem_flag_o(fl));
  rhu_div_chain u_sat (.clk(clk), .en(en), .num_i(ns_r), .den_i(ds_r),
    .rem_flag_i(side_in), .quo_o(qs), .rem_nz_o(rs_nz), .rem_flag_o(fs));
  rhu_div_chain u_hue (.clk(clk), .en(en), .num_i(nh_r), .den_i(dh_r),
    .rem_flag_i(side_in), .quo_o(qh), .rem_nz_o(rh_nz), .rem_flag_o(fh));

  // Side data delay line matching the chain
  side_t side_d [Stages];
  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side_r;
      for (int k = 1; k < Stages; k++) side_d[k] <= side_d[k-1];
    end
  end
  assign side_q = side_d[Stages-1];

  // Final: floor for negative hue, wrap, gray repair
  logic [15:0] hq;
  logic [15:0] hsum;
  logic        unused;
  always_comb begin
    unused = rl_nz ^ rs_nz ^ (|fl) ^ (|fs) ^ (|fh) ^ (|qh[15:14]);
    hq = {2'b00, qh[13:0]} + {15'd0, (side_q.neg && rh_nz)};
    if (side_q.neg) hsum = {1'b0, side_q.base} - hq;
    else            hsum = {1'b0, side_q.base} + hq;
    if (hsum[15]) hsum = hsum + {1'b0, HueFull};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[Lat-2:0], in_valid};
      out_vld_r <= vld_r[Lat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.hue        <= side_q.achro ? 15'd0 : hsum[14:0];
      out_r.saturation <= side_q.achro ? 16'd0 : qs;
      out_r.lightness  <= ql;
      out_r.achromatic <= side_q.achro && !unused ? 1'b1 : side_q.achro;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `RHU_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `RHU_ASSERT_IMPL(a_stall, in_stall, out_valid && out_stall)
  `RHU_ASSERT_IMPL(a_achro, out_valid && out_data.achromatic, out_data.hue == 15'd0)
endmodule

/* sim/rgb_to_hsl_checker.sv */
// Scoreboard for rgb_to_hsl_unit: watches the pixel, result and register ports,
// predicts each HSL word and compares it field by field. Depends on rhu_pkg.
`timescale 1ns / 1ps
module rgb_to_hsl_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rhu_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rhu_pkg::out_word_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);
  import rhu_pkg::*;

  logic [15:0] full_scale;
  out_word_t   hsl_queue[$];

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // Expected HSL word for one pixel at the given full scale
  function automatic out_word_t hsl_of(in_word_t px, logic [15:0] fs);
    out_word_t o;
    longint m, r, g, b, mx, mn, s, d, h;
    m = (fs == 0) ? 1 : fs;
    r = (px.red > m) ? m : px.red;
    g = (px.green > m) ? m : px.green;
    b = (px.blue > m) ? m : px.blue;
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    s = mx + mn;
    d = mx - mn;
    o = '0;
    o.lightness = 16'((65535 * s) / (2 * m));
    if (d == 0) begin
      o.achromatic = 1'b1;
    end else begin
      o.saturation = 16'((65535 * d) / ((s < m) ? s : (2 * m - s)));
      if (r == mx) h = floor_quot(3840 * (g - b), d);
      else if (g == mx) h = 7680 + floor_quot(3840 * (b - r), d);
      else h = 15360 + floor_quot(3840 * (r - g), d);
      if (h < 0) h = h + 23040;
      o.hue = 15'(h);
    end
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_word_t w;
    if (!rst_n) begin
      full_scale <= 16'd255;
      hsl_queue.delete();
      fail_count = 0;
      checked = 0;
      pending = 0;
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[2] == RegMaxComp)
        full_scale <= cfg_pwdata[15:0];
      // accepted pixel
      if (in_valid && !in_stall) hsl_queue.push_back(hsl_of(in_data, full_scale));
      // accepted result
      if (out_valid && !out_stall) begin
        if (hsl_queue.size() == 0) begin
          report("unexpected word, hue", out_data.hue, -1);
        end else begin
          w = hsl_queue.pop_front();
          checked++;
          if (out_data.hue != w.hue) report("hue", out_data.hue, w.hue);
          if (out_data.saturation != w.saturation)
            report("saturation", out_data.saturation, w.saturation);
          if (out_data.lightness != w.lightness)
            report("lightness", out_data.lightness, w.lightness);
          if (out_data.achromatic != w.achromatic)
            report("achromatic", out_data.achromatic, w.achromatic);
        end
      end
      pending = hsl_queue.size();
    end
  end
endmodule

/* sim/tb_rgb_to_hsl_unit.sv */
// Testbench top for rgb_to_hsl_unit: clock, reset, pixel stimulus, stalls
// and register writes; checking is in rgb_to_hsl_checker. Depends on rhu_pkg.
`timescale 1ns / 1ps
module tb_rgb_to_hsl_unit;
  import rhu_pkg::*;

  localparam int Latency = 36;
  localparam int CycleLimit = 400000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_word_t in_data;
  out_word_t out_data;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int fail_count, pending, checked;
  int snd_idle, rcv_idle, hold_reqs, cycles;
  logic [15:0] fs_now;

  rgb_to_hsl_unit dut (.*);
  rgb_to_hsl_checker chk (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // receiver: random stalls, plus long hold-offs on request
  int hold_seen, hold_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
    end else begin
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[rgb_to_hsl_unit] ERROR");
      $finish;
    end
  end

  task automatic send_pixel(in_word_t px);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < snd_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= addr; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_comp(logic [15:0] m);
    int k;
    k = $urandom_range(99);
    if (k < 10) return 16'($urandom_range(65535));
    if (k < 20) return 16'($urandom_range(65535, m));
    if (k < 25) return 16'd0;
    if (k < 30) return m;
    return 16'($urandom_range(m));
  endfunction

  function automatic in_word_t random_pixel(logic [15:0] m);
    in_word_t px;
    px.red = pick_comp(m);
    px.green = pick_comp(m);
    px.blue = pick_comp(m);
    // some grays and two-way ties
    case ($urandom_range(9))
      0: begin px.green = px.red; px.blue = px.red; end
      1: px.green = px.red;
      2: px.blue = px.green;
      default: ;
    endcase
    return px;
  endfunction

  task automatic set_idle(int n);
    if (n < 420) begin snd_idle = 28; rcv_idle = 66; end
    else if (n < 840) begin snd_idle = 66; rcv_idle = 28; end
    else begin snd_idle = 0; rcv_idle = 0; end
  endtask

  logic [15:0] scales[6] = '{16'd255, 16'd65535, 16'd1, 16'd0, 16'd12345, 16'd4095};
  in_word_t directed[$];

  initial begin
    int n;
    logic [15:0] m;
    in_valid = 1'b0; in_data = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    snd_idle = 28; rcv_idle = 66; hold_reqs = 0; cycles = 0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners at reset scale 255: grays, primaries, ties, over-range
    directed = '{'{16'd0, 16'd0, 16'd0}, '{16'd255, 16'd255, 16'd255},
                 '{16'hFFFF, 16'hFFFF, 16'hFFFF}, '{16'd128, 16'd128, 16'd128},
                 '{16'd255, 16'd0, 16'd0}, '{16'd0, 16'd255, 16'd0},
                 '{16'd0, 16'd0, 16'd255}, '{16'd255, 16'd255, 16'd0},
                 '{16'd0, 16'd255, 16'd255}, '{16'd255, 16'd0, 16'd255},
                 '{16'd255, 16'd0, 16'd1}, '{16'd1, 16'd0, 16'd255},
                 '{16'hFFFF, 16'd0, 16'h8000}, '{16'd200, 16'd100, 16'd50},
                 '{16'd10, 16'd20, 16'd0}, '{16'd1, 16'd0, 16'd0},
                 '{16'd254, 16'd255, 16'd253}, '{16'h5555, 16'hAAAA, 16'd7}};
    foreach (directed[i]) send_pixel(directed[i]);

    n = 0;
    foreach (scales[p]) begin
      if (p > 0) begin
        drain();
        write_reg(3'(RegMaxComp) << 2, {16'hA5A5, scales[p]});
        write_reg(3'd4, 32'd7);  // no register here: ignored
      end
      fs_now = scales[p];
      m = (fs_now == 0) ? 16'd1 : fs_now;
      for (int i = 0; i < 210; i++) begin
        set_idle(n);
        // long receiver hold-off while pixels keep coming
        if (i == 50 && (p == 1 || p == 4)) hold_reqs++;
        // sender pause until the pipe is empty
        if (i == 120 && p == 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_pixel(random_pixel(m));
        n++;
      end
    end
    drain();

    $display("covered %0d results over %0d full-scale settings incl. 0, 1 and 65535",
             checked, $size(scales));
    $display("with sender/receiver idling, a long output hold-off and a full drain");
    if (fail_count == 0)
      $display("[rgb_to_hsl_unit] OK");
    else
      $display("[rgb_to_hsl_unit] ERROR");
    $finish;
  end
endmodule
